/* rtl/pfe_pkg.sv */
// Shared constants, types and character helpers of the printf format engine.
`default_nettype none

package pfe_pkg;

    // Argument and digit sizing
    localparam int ARG_BITS   = 32;
    localparam int DEC_DIGITS = ((ARG_BITS * 1233) >> 12) + 1;
    localparam int HEX_DIGITS = (ARG_BITS + 3) / 4;
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int ND_W       = $clog2(DEC_DIGITS + 1);
    localparam int IDX_W      = $clog2(DEC_DIGITS);
    localparam int POS_W      = $clog2(DEC_DIGITS + 12);
    localparam int BIT_W      = $clog2(ARG_BITS);

    // Port field widths
    localparam int FMT_W      = 8;
    localparam int ARGIN_W    = 32;
    localparam int LEN_W      = 16;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_D  = 8'h64;
    localparam logic [7:0] CH_LO_P  = 8'h70;
    localparam logic [7:0] CH_LO_S  = 8'h73;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    localparam logic [LEN_W-1:0] COUNT_MAX = {LEN_W{1'b1}};

    // Commands from the controller to the datapath
    typedef struct packed {
        logic put_echo;
        logic put_term;
        logic spec_open;
        logic set_pad;
        logic set_width;
        logic conv_load;
        logic conv_step;
        logic plan;
        logic emit;
    } pfe_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
        logic is_nul;
        logic is_pct;
        logic is_zero;
        logic is_width;
        logic is_dec;
        logic is_hex;
        logic is_ptr;
        logic is_str;
        logic dab_done;
        logic emit_last;
    } pfe_stat_t;

    // Digit value to its ASCII character in either hex case.
    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        begin
            base = upper ? CH_UP_A : CH_LO_A;
            if (nib < 4'd10) begin
                hex_char = CH_ZERO + {4'h0, nib};
            end else begin
                hex_char = base + {4'h0, nib} - 8'd10;
            end
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/printf_format_engine.sv */
// Top level of the printf-style integer formatter: controller plus datapath.
// An echoed byte or terminator is registered and appears in the cycle after its input beat.
// Plain format bytes are taken one per cycle while the output register is free; %x, %X and %p
// load, plan and emit; %d first runs the one-bit-per-cycle binary-to-BCD shifter over all argument
// bits; a conversion takes no new byte until done. Output characters stream at one beat per cycle
// while m_tready is high. Reset (aresetn low, synchronous) clears the controller state, padding,
// width, character count and the output valid.
`default_nettype none

module printf_format_engine
    import pfe_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // format_byte [7:0], argument [39:8]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // out_char [7:0], total_length [23:8]
    output logic                      m_tlast
);

    pfe_cmd_t  cmd;
    pfe_stat_t stat;

    // Format parser and sequencer
    pfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Conversion datapath and output register
    pfe_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

/* rtl/pfe_dp.sv */
// Datapath: byte decode, conversion registers, BCD shifter, emission and output register.
`default_nettype none

module pfe_dp
    import pfe_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // format_byte [7:0], argument [39:8]
    input  wire pfe_cmd_t             cmd,
    output pfe_stat_t                 stat,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // out_char [7:0], total_length [23:8]
    output logic                      m_tlast
);

    logic [FMT_W-1:0]    fmt;
    logic [ARG_BITS-1:0] arg_in;
    logic                neg_in;
    logic [ARG_BITS-1:0] mag_in;

    logic [ARG_BITS-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next, bcd_adj;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic                neg_reg, neg_next;
    logic                ptr_reg, ptr_next;
    logic                upper_reg, upper_next;
    logic                pad_zero_reg, pad_zero_next;
    logic [3:0]          width_reg, width_next;
    logic [LEN_W-1:0]    count_reg, count_next;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    pre_end_reg, pre_end_next;
    logic [POS_W-1:0]    pad_end_reg, pad_end_next;
    logic [POS_W-1:0]    total_reg, total_next;
    logic [IDX_W-1:0]    didx_reg, didx_next;
    logic [7:0]          padc_reg, padc_next;

    logic                m_valid_reg, m_valid_next;
    logic [7:0]          char_reg, char_next;
    logic                last_reg, last_next;
    logic [LEN_W-1:0]    len_reg, len_next;

    logic [ND_W-1:0]     nd;
    logic [POS_W-1:0]    w_eff, used, npad, npre;
    logic [7:0]          emit_char;
    logic                out_free;
    logic                put;

    // Field extraction and byte classes
    assign fmt    = s_tdata[FMT_W-1:0];
    assign arg_in = ARG_BITS'(s_tdata[FMT_W +: ARGIN_W]);
    assign neg_in = (fmt == CH_LO_D) && arg_in[ARG_BITS-1];
    assign mag_in = neg_in ? (ARG_BITS'(0) - arg_in) : arg_in;

    assign out_free = !m_valid_reg || m_tready;
    assign put      = cmd.put_echo || cmd.emit;

    always_comb begin
        stat           = '0;
        stat.out_free  = out_free;
        stat.is_nul    = (fmt == CH_NUL);
        stat.is_pct    = (fmt == CH_PCT);
        stat.is_zero   = (fmt == CH_ZERO);
        stat.is_width  = (fmt >= CH_ONE) && (fmt <= CH_NINE);
        stat.is_dec    = (fmt == CH_LO_D);
        stat.is_hex    = (fmt == CH_LO_X) || (fmt == CH_UP_X);
        stat.is_ptr    = (fmt == CH_LO_P);
        stat.is_str    = (fmt == CH_LO_S);
        stat.dab_done  = (bit_reg == BIT_W'(ARG_BITS - 1));
        stat.emit_last = (pos_reg == total_reg - POS_W'(1));
    end

    // Add-3 correction of every BCD digit before the shift
    always_comb begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    // Digit count: position of the highest nonzero digit, at least one
    always_comb begin
        nd = ND_W'(1);
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] != 4'h0) begin
                nd = ND_W'(i + 1);
            end
        end
    end

    // Layout of one conversion: prefix, padding, digits
    assign w_eff = ptr_reg ? POS_W'(HEX_DIGITS) : POS_W'(width_reg);
    assign used  = POS_W'(nd) + POS_W'(neg_reg);
    assign npad  = (w_eff > used) ? (w_eff - used) : '0;
    assign npre  = ptr_reg ? POS_W'(2) : POS_W'(neg_reg);

    // Character at the current position
    always_comb begin
        if (pos_reg < pre_end_reg) begin
            if (ptr_reg) begin
                emit_char = (pos_reg == '0) ? CH_ZERO : CH_LO_X;
            end else begin
                emit_char = CH_MINUS;
            end
        end else if (pos_reg < pad_end_reg) begin
            emit_char = padc_reg;
        end else begin
            emit_char = hex_char(bcd_reg[{didx_reg, 2'b00} +: 4], upper_reg);
        end
    end

    // Conversion and specification registers
    always_comb begin
        mag_next      = mag_reg;
        bcd_next      = bcd_reg;
        bit_next      = bit_reg;
        neg_next      = neg_reg;
        ptr_next      = ptr_reg;
        upper_next    = upper_reg;
        pad_zero_next = pad_zero_reg;
        width_next    = width_reg;
        pos_next      = pos_reg;
        pre_end_next  = pre_end_reg;
        pad_end_next  = pad_end_reg;
        total_next    = total_reg;
        didx_next     = didx_reg;
        padc_next     = padc_reg;

        if (cmd.spec_open || cmd.put_term) begin
            pad_zero_next = 1'b0;
            width_next    = 4'h0;
        end
        if (cmd.set_pad) begin
            pad_zero_next = 1'b1;
        end
        if (cmd.set_width) begin
            width_next = fmt[3:0];
        end
        if (cmd.conv_load) begin
            mag_next   = mag_in;
            bit_next   = '0;
            neg_next   = neg_in;
            ptr_next   = (fmt == CH_LO_P);
            upper_next = (fmt == CH_UP_X);
            bcd_next   = (fmt == CH_LO_D) ? '0 : BCD_W'(arg_in);
        end
        if (cmd.conv_step) begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[ARG_BITS-1]};
            mag_next = {mag_reg[ARG_BITS-2:0], 1'b0};
            bit_next = bit_reg + BIT_W'(1);
        end
        if (cmd.plan) begin
            pos_next     = '0;
            pre_end_next = npre;
            pad_end_next = npre + npad;
            total_next   = npre + npad + POS_W'(nd);
            didx_next    = IDX_W'(nd - ND_W'(1));
            padc_next    = (ptr_reg || pad_zero_reg) ? CH_ZERO : CH_SPACE;
        end
        if (cmd.emit) begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg >= pad_end_reg) begin
                didx_next = didx_reg - IDX_W'(1);
            end
        end
    end

    // Saturating character count, cleared by the terminator
    always_comb begin
        count_next = count_reg;
        if (cmd.put_term) begin
            count_next = '0;
        end else if (put && (count_reg != COUNT_MAX)) begin
            count_next = count_reg + LEN_W'(1);
        end
    end

    // Output register: a new beat may load while the previous one is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        len_next     = len_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.put_echo) begin
            m_valid_next = 1'b1;
            char_next    = fmt;
            last_next    = 1'b1;
            len_next     = '0;
        end else if (cmd.put_term) begin
            m_valid_next = 1'b1;
            char_next    = CH_NUL;
            last_next    = 1'b1;
            len_next     = count_reg;
        end else if (cmd.emit) begin
            m_valid_next = 1'b1;
            char_next    = emit_char;
            last_next    = stat.emit_last;
            len_next     = '0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_zero_reg <= 1'b0;
            width_reg    <= 4'h0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            pad_zero_reg <= pad_zero_next;
            width_reg    <= width_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        bit_reg     <= bit_next;
        neg_reg     <= neg_next;
        ptr_reg     <= ptr_next;
        upper_reg   <= upper_next;
        pos_reg     <= pos_next;
        pre_end_reg <= pre_end_next;
        pad_end_reg <= pad_end_next;
        total_reg   <= total_next;
        didx_reg    <= didx_next;
        padc_reg    <= padc_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
        len_reg     <= len_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {len_reg, char_reg};
    assign m_tlast  = last_reg;

    // A terminator beat always closes the item.
    a_term_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (char_reg == CH_NUL)) |-> last_reg)
        else $error("terminator beat without last");

    // The count never moves past saturation back to zero without a terminator.
    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(count_reg) == COUNT_MAX && !$past(cmd.put_term)) |-> (count_reg == COUNT_MAX))
        else $error("character count wrapped");

endmodule

`default_nettype wire

/* rtl/pfe_ctrl.sv */
// Controller: format parsing state and sequencing of the conversion datapath.
`default_nettype none

module pfe_ctrl
    import pfe_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire pfe_stat_t stat,
    output pfe_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DAB  = 2'd1;
    localparam logic [1:0] S_PLAN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       in_spec_reg, in_spec_next;
    logic       accept;

    // Bytes are taken only when idle and the output register can take a beat
    assign s_tready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    // Next state and command decode
    always_comb begin
        state_next   = state_reg;
        in_spec_next = in_spec_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (stat.is_nul) begin
                        cmd.put_term = 1'b1;
                        in_spec_next = 1'b0;
                    end else if (!in_spec_reg) begin
                        if (stat.is_pct) begin
                            cmd.spec_open = 1'b1;
                            in_spec_next  = 1'b1;
                        end else begin
                            cmd.put_echo = 1'b1;
                        end
                    end else if (stat.is_zero) begin
                        cmd.set_pad = 1'b1;
                    end else if (stat.is_width) begin
                        cmd.set_width = 1'b1;
                    end else begin
                        in_spec_next = 1'b0;
                        if (stat.is_dec) begin
                            cmd.conv_load = 1'b1;
                            state_next    = S_DAB;
                        end else if (stat.is_hex || stat.is_ptr) begin
                            cmd.conv_load = 1'b1;
                            state_next    = S_PLAN;
                        end else if (!stat.is_str) begin
                            cmd.put_echo = 1'b1;
                        end
                    end
                end
            end
            S_DAB: begin
                cmd.conv_step = 1'b1;
                if (stat.dab_done) begin
                    state_next = S_PLAN;
                end
            end
            S_PLAN: begin
                cmd.plan   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.emit_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            in_spec_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_spec_reg <= in_spec_next;
        end
    end

    // At most one beat is written into the output register per cycle.
    a_one_put: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.put_echo, cmd.put_term, cmd.emit}) <= 1)
        else $error("more than one output write in a cycle");

    // A decimal load is followed by the BCD shifter.
    a_dec_dab: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.conv_load && stat.is_dec) |=> (state_reg == S_DAB))
        else $error("decimal conversion skipped the shifter");

    // Planning is always followed by emission.
    a_plan_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.plan |=> (state_reg == S_EMIT))
        else $error("plan not followed by emission");

    // The conversion flag is clear whenever a conversion is under way.
    a_spec_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !in_spec_reg)
        else $error("conversion flag set during a conversion");

endmodule

`default_nettype wire
